// ===== hdl/lp2sc_pkg.sv =====
// Shared types and constants for the length-prefix to start-code converter.
// Used by lp2sc_ctrl, lp2sc_dp and the top level; no dependencies.
package lp2sc_pkg;

    localparam int PARAM_STORE_BYTES = 56;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LEN_CUT  = 3'd1;
    localparam logic [2:0] ERR_OVERRUN  = 3'd2;
    localparam logic [2:0] ERR_SIGN     = 3'd3;
    localparam logic [2:0] ERR_UNIT     = 3'd4;
    localparam logic [2:0] ERR_FULL     = 3'd5;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0] NAL_IDR       = 5'd5;
    localparam logic [2:0] HEADER_BYTES  = 3'd4;

    typedef enum logic [2:0] {
        CP_HEADER, CP_LENSIZE, CP_SPSCOUNT, CP_LENHI,
        CP_LENLO, CP_PAYLOAD, CP_PPSCOUNT, CP_DONE
    } cp_t;

    typedef enum logic [1:0] {
        PP_PREFIX, PP_FIRST, PP_PAYLOAD, PP_DROP
    } pp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISP, ST_SCW, ST_DRD, ST_DEM, ST_SC, ST_PAY, ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        SRC_STORE, SRC_SC, SRC_PAY, SRC_TAIL
    } src_t;

    typedef struct packed {
        logic accept;
        logic emit;
        src_t sel;
        logic last;
        logic scw_we;
        logic cnt_clr;
        logic cnt_inc;
        logic tail_done;
    } cmd_t;

    typedef struct packed {
        logic can_load;
        logic pl_cfgw;
        logic pl_dump;
        logic pl_sc;
        logic pl_pay;
        logic pl_tail;
        logic scw_last;
        logic dump_last;
        logic sc_last;
    } stat_t;

endpackage

// ===== hdl/lp2sc_ctrl.sv =====
// Sequencer for the converter: walks store writes, store dump, start code,
// payload byte and status item for each request. Depends on lp2sc_pkg.
module lp2sc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lp2sc_pkg::stat_t stat,
    output lp2sc_pkg::cmd_t  cmd
);

    lp2sc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lp2sc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.sel       = lp2sc_pkg::SRC_TAIL;
        s_tready      = 1'b0;
        case (state_reg)
            lp2sc_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                    state_next = lp2sc_pkg::ST_DISP;
            end
            lp2sc_pkg::ST_DISP:
            begin
                cmd.cnt_clr = 1'b1;
                if (stat.pl_cfgw)
                    state_next = lp2sc_pkg::ST_SCW;
                else if (stat.pl_dump)
                    state_next = lp2sc_pkg::ST_DRD;
                else if (stat.pl_sc)
                    state_next = lp2sc_pkg::ST_SC;
                else if (stat.pl_pay)
                    state_next = lp2sc_pkg::ST_PAY;
                else if (stat.pl_tail)
                    state_next = lp2sc_pkg::ST_TAIL;
                else
                    state_next = lp2sc_pkg::ST_IDLE;
            end
            lp2sc_pkg::ST_SCW:
            begin
                cmd.scw_we = 1'b1;
                if (stat.scw_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = stat.pl_tail ? lp2sc_pkg::ST_TAIL : lp2sc_pkg::ST_IDLE;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end
            lp2sc_pkg::ST_DRD:
                state_next = lp2sc_pkg::ST_DEM;
            lp2sc_pkg::ST_DEM:
            begin
                cmd.sel = lp2sc_pkg::SRC_STORE;
                if (stat.can_load)
                begin
                    cmd.emit = 1'b1;
                    if (stat.dump_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = lp2sc_pkg::ST_SC;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = lp2sc_pkg::ST_DRD;
                    end
                end
            end
            lp2sc_pkg::ST_SC:
            begin
                cmd.sel  = lp2sc_pkg::SRC_SC;
                cmd.last = stat.sc_last && !stat.pl_pay && !stat.pl_tail;
                if (stat.can_load)
                begin
                    cmd.emit = 1'b1;
                    if (stat.sc_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        if (stat.pl_pay)
                            state_next = lp2sc_pkg::ST_PAY;
                        else if (stat.pl_tail)
                            state_next = lp2sc_pkg::ST_TAIL;
                        else
                            state_next = lp2sc_pkg::ST_IDLE;
                    end
                    else
                        cmd.cnt_inc = 1'b1;
                end
            end
            lp2sc_pkg::ST_PAY:
            begin
                cmd.sel  = lp2sc_pkg::SRC_PAY;
                cmd.last = !stat.pl_tail;
                if (stat.can_load)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.pl_tail ? lp2sc_pkg::ST_TAIL : lp2sc_pkg::ST_IDLE;
                end
            end
            lp2sc_pkg::ST_TAIL:
            begin
                cmd.sel  = lp2sc_pkg::SRC_TAIL;
                cmd.last = 1'b1;
                if (stat.can_load)
                begin
                    cmd.emit      = 1'b1;
                    cmd.tail_done = 1'b1;
                    state_next    = lp2sc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lp2sc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/lp2sc_dp.sv =====
// Datapath: configuration parser with parameter-set store, packet parser,
// per-request plan registers and the output register. Depends on lp2sc_pkg.
module lp2sc_dp #(
    parameter int PARAM_STORE_BYTES = lp2sc_pkg::PARAM_STORE_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lp2sc_pkg::cmd_t  cmd,
    input  logic             in_opcode,
    input  logic [7:0]       in_byte,
    input  logic             in_eob,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    output lp2sc_pkg::stat_t stat
);

    localparam int ADDR_W = $clog2(PARAM_STORE_BYTES);
    localparam int LEN_W  = $clog2(PARAM_STORE_BYTES + 1);
    localparam logic [LEN_W-1:0] STORE_MAX = LEN_W'(PARAM_STORE_BYTES);

    logic [7:0] mem [PARAM_STORE_BYTES];
    logic [7:0] rd_data_reg;

    logic [LEN_W-1:0] plen_reg, plen_next;
    lp2sc_pkg::cp_t   cp_reg, cp_next;
    logic [2:0]       cpos_reg, cpos_next;
    logic [7:0]       units_reg, units_next;
    logic [15:0]      ubl_reg, ubl_next;
    logic             ppsd_reg, ppsd_next;
    logic [2:0]       cerr_reg, cerr_next;
    logic [1:0]       seen_reg, seen_next;

    lp2sc_pkg::pp_t   pp_reg, pp_next;
    logic [23:0]      acc_reg, acc_next;
    logic [1:0]       pc_reg, pc_next;
    logic [30:0]      nal_reg, nal_next;
    logic             first_reg, first_next;
    logic [2:0]       pend_reg, pend_next;

    logic pl_cfgw_reg, pl_dump_reg, pl_sc_reg, pl_sc4_reg, pl_pay_reg;
    logic pl_tail_reg, pl_merge_reg, pl_clr_reg, pl_sm_reg, pl_pm_reg;
    logic [7:0] pl_byte_reg;
    logic [1:0] pl_kind_reg;
    logic [2:0] pl_err_reg;
    logic pl_cfgw_next, pl_dump_next, pl_sc_next, pl_sc4_next, pl_pay_next;
    logic pl_tail_next, pl_merge_next, pl_clr_next, pl_sm_next, pl_pm_next;
    logic [1:0] pl_kind_next;
    logic [2:0] pl_err_next;

    logic [ADDR_W-1:0] cnt_reg;
    logic              pay_we;
    logic [31:0]       acc_full;
    logic [16:0]       unit_need;
    logic [2:0]        err_v;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [1:0]  out_kind_reg;
    logic        out_last_reg;
    logic [7:0]  o_byte;
    logic [1:0]  o_kind;
    logic [2:0]  o_err;
    logic        o_sm, o_pm;

    assign acc_full  = {acc_reg, in_byte};
    assign unit_need = 17'(plen_reg) + 17'd4 + 17'({ubl_reg[15:8], in_byte});

    always_comb
    begin
        plen_next = plen_reg;   cp_next   = cp_reg;    cpos_next  = cpos_reg;
        units_next = units_reg; ubl_next  = ubl_reg;   ppsd_next  = ppsd_reg;
        cerr_next = cerr_reg;   seen_next = seen_reg;
        pp_next   = pp_reg;     acc_next  = acc_reg;   pc_next    = pc_reg;
        nal_next  = nal_reg;    first_next = first_reg; pend_next = pend_reg;
        pl_cfgw_next = 1'b0;    pl_dump_next = 1'b0;   pl_sc_next = 1'b0;
        pl_sc4_next  = 1'b0;    pl_pay_next  = 1'b0;   pl_tail_next = 1'b0;
        pl_merge_next = 1'b0;   pl_clr_next  = 1'b0;   pl_sm_next = 1'b0;
        pl_pm_next   = 1'b0;    pl_kind_next = lp2sc_pkg::KIND_BYTE;
        pl_err_next  = lp2sc_pkg::ERR_NONE;
        pay_we = 1'b0;
        err_v  = lp2sc_pkg::ERR_NONE;

        if (cmd.accept && in_opcode)
        begin
            case (cp_reg)
                lp2sc_pkg::CP_HEADER:
                begin
                    if (cpos_reg == 3'd0)
                        plen_next = '0;
                    cpos_next = cpos_reg + 3'd1;
                    if (cpos_next >= lp2sc_pkg::HEADER_BYTES)
                        cp_next = lp2sc_pkg::CP_LENSIZE;
                end
                lp2sc_pkg::CP_LENSIZE:
                    cp_next = lp2sc_pkg::CP_SPSCOUNT;
                lp2sc_pkg::CP_SPSCOUNT:
                begin
                    units_next = {3'd0, in_byte[4:0]};
                    if (in_byte[4:0] == 5'd0)
                        cp_next = lp2sc_pkg::CP_PPSCOUNT;
                    else
                    begin
                        seen_next[0] = 1'b1;
                        cp_next      = lp2sc_pkg::CP_LENHI;
                    end
                end
                lp2sc_pkg::CP_LENHI:
                begin
                    ubl_next = {in_byte, 8'd0};
                    cp_next  = lp2sc_pkg::CP_LENLO;
                end
                lp2sc_pkg::CP_LENLO:
                begin
                    ubl_next = {ubl_reg[15:8], in_byte};
                    if (unit_need > 17'(PARAM_STORE_BYTES))
                    begin
                        cerr_next = lp2sc_pkg::ERR_FULL;
                        plen_next = '0;
                        cp_next   = lp2sc_pkg::CP_DONE;
                    end
                    else
                    begin
                        // start code goes into the store after this request, in ST_SCW
                        pl_cfgw_next = 1'b1;
                        if (ubl_next == 16'd0)
                        begin
                            units_next = units_reg - 8'd1;
                            if (units_next != 8'd0)
                                cp_next = lp2sc_pkg::CP_LENHI;
                            else if (!ppsd_reg)
                                cp_next = lp2sc_pkg::CP_PPSCOUNT;
                            else
                                cp_next = lp2sc_pkg::CP_DONE;
                        end
                        else
                            cp_next = lp2sc_pkg::CP_PAYLOAD;
                    end
                end
                lp2sc_pkg::CP_PAYLOAD:
                begin
                    if (plen_reg < STORE_MAX)
                    begin
                        pay_we    = 1'b1;
                        plen_next = plen_reg + LEN_W'(1);
                    end
                    ubl_next = ubl_reg - 16'd1;
                    if (ubl_next == 16'd0)
                    begin
                        units_next = units_reg - 8'd1;
                        if (units_next != 8'd0)
                            cp_next = lp2sc_pkg::CP_LENHI;
                        else if (!ppsd_reg)
                            cp_next = lp2sc_pkg::CP_PPSCOUNT;
                        else
                            cp_next = lp2sc_pkg::CP_DONE;
                    end
                end
                lp2sc_pkg::CP_PPSCOUNT:
                begin
                    units_next = in_byte;
                    ppsd_next  = 1'b1;
                    if (in_byte != 8'd0)
                    begin
                        seen_next[1] = 1'b1;
                        cp_next      = lp2sc_pkg::CP_LENHI;
                    end
                    else
                        cp_next = lp2sc_pkg::CP_DONE;
                end
                default:
                    cp_next = cp_reg;
            endcase
            if (in_eob)
            begin
                err_v = cerr_next;
                if (cp_next != lp2sc_pkg::CP_DONE && err_v == lp2sc_pkg::ERR_NONE)
                    err_v = lp2sc_pkg::ERR_UNIT;
                pl_tail_next = 1'b1;
                pl_kind_next = lp2sc_pkg::KIND_STATUS;
                pl_err_next  = err_v;
                pl_clr_next  = (err_v != lp2sc_pkg::ERR_NONE);
                pl_sm_next   = !seen_next[0];
                pl_pm_next   = !seen_next[1];
                cp_next = lp2sc_pkg::CP_HEADER;
                cpos_next = 3'd0;  units_next = 8'd0; ubl_next  = 16'd0;
                ppsd_next = 1'b0;  cerr_next  = 3'd0; seen_next = 2'd0;
            end
        end

        if (cmd.accept && !in_opcode)
        begin
            case (pp_reg)
                lp2sc_pkg::PP_PREFIX:
                begin
                    acc_next = acc_full[23:0];
                    pc_next  = pc_reg + 2'd1;
                    if (pc_reg == 2'd3)
                    begin
                        if (acc_full[31])
                        begin
                            pend_next = lp2sc_pkg::ERR_SIGN;
                            pp_next   = lp2sc_pkg::PP_DROP;
                        end
                        else
                        begin
                            nal_next = acc_full[30:0];
                            if (acc_full[30:0] == 31'd0)
                            begin
                                pl_sc_next  = 1'b1;
                                pl_sc4_next = first_reg;
                                first_next  = 1'b0;
                            end
                            else
                                pp_next = lp2sc_pkg::PP_FIRST;
                        end
                        acc_next = 24'd0;
                    end
                end
                lp2sc_pkg::PP_FIRST, lp2sc_pkg::PP_PAYLOAD:
                begin
                    if (pp_reg == lp2sc_pkg::PP_FIRST)
                    begin
                        pl_dump_next = ((in_byte[4:0] & lp2sc_pkg::NAL_TYPE_MASK)
                                        == lp2sc_pkg::NAL_IDR) && (plen_reg != '0);
                        pl_sc_next   = 1'b1;
                        pl_sc4_next  = first_reg;
                        first_next   = 1'b0;
                    end
                    pl_pay_next = 1'b1;
                    nal_next    = nal_reg - 31'd1;
                    pp_next     = (nal_next == 31'd0) ? lp2sc_pkg::PP_PREFIX
                                                      : lp2sc_pkg::PP_PAYLOAD;
                end
                default:
                    pp_next = pp_reg;
            endcase
            if (in_eob)
            begin
                err_v = pend_next;
                if (err_v == lp2sc_pkg::ERR_NONE)
                begin
                    if (pp_next == lp2sc_pkg::PP_PREFIX && pc_next != 2'd0)
                        err_v = lp2sc_pkg::ERR_LEN_CUT;
                    else if (pp_next == lp2sc_pkg::PP_FIRST
                             || pp_next == lp2sc_pkg::PP_PAYLOAD)
                        err_v = lp2sc_pkg::ERR_OVERRUN;
                end
                pl_err_next  = err_v;
                pl_kind_next = lp2sc_pkg::KIND_ERROR;
                // full result budget: carry the code on the payload byte
                pl_merge_next = (err_v != lp2sc_pkg::ERR_NONE) && pl_dump_next
                                && first_reg && (plen_reg == STORE_MAX);
                pl_tail_next  = (err_v != lp2sc_pkg::ERR_NONE) && !pl_merge_next;
                pp_next = lp2sc_pkg::PP_PREFIX; acc_next = 24'd0; pc_next = 2'd0;
                nal_next = 31'd0; first_next = 1'b1; pend_next = 3'd0;
            end
        end

        if (cmd.scw_we)
            plen_next = plen_reg + LEN_W'(1);
        if (cmd.tail_done && pl_clr_reg)
            plen_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
            mem[plen_reg[ADDR_W-1:0]] <= in_byte;
        else if (cmd.scw_we)
            mem[plen_reg[ADDR_W-1:0]] <= (cnt_reg == ADDR_W'(3)) ? 8'd1 : 8'd0;
        rd_data_reg <= mem[cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;  cp_reg <= lp2sc_pkg::CP_HEADER; cpos_reg <= '0;
            units_reg <= '0; ubl_reg <= '0; ppsd_reg <= 1'b0; cerr_reg <= '0;
            seen_reg <= '0;  pp_reg <= lp2sc_pkg::PP_PREFIX; acc_reg <= '0;
            pc_reg <= '0;    nal_reg <= '0; first_reg <= 1'b1; pend_reg <= '0;
            pl_cfgw_reg <= 1'b0; pl_dump_reg <= 1'b0; pl_sc_reg <= 1'b0;
            pl_sc4_reg <= 1'b0;  pl_pay_reg <= 1'b0;  pl_tail_reg <= 1'b0;
            pl_merge_reg <= 1'b0; pl_clr_reg <= 1'b0; pl_sm_reg <= 1'b0;
            pl_pm_reg <= 1'b0;   pl_kind_reg <= '0;   pl_err_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg <= plen_next;  cp_reg <= cp_next;   cpos_reg <= cpos_next;
            units_reg <= units_next; ubl_reg <= ubl_next; ppsd_reg <= ppsd_next;
            cerr_reg <= cerr_next;  seen_reg <= seen_next;
            pp_reg <= pp_next;      acc_reg <= acc_next; pc_reg <= pc_next;
            nal_reg <= nal_next;    first_reg <= first_next; pend_reg <= pend_next;
            if (cmd.accept)
            begin
                pl_cfgw_reg <= pl_cfgw_next; pl_dump_reg <= pl_dump_next;
                pl_sc_reg <= pl_sc_next;     pl_sc4_reg <= pl_sc4_next;
                pl_pay_reg <= pl_pay_next;   pl_tail_reg <= pl_tail_next;
                pl_merge_reg <= pl_merge_next; pl_clr_reg <= pl_clr_next;
                pl_sm_reg <= pl_sm_next;     pl_pm_reg <= pl_pm_next;
                pl_kind_reg <= pl_kind_next; pl_err_reg <= pl_err_next;
            end
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + ADDR_W'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pl_byte_reg <= in_byte;
        if (cmd.emit)
        begin
            out_data_reg <= {3'd0, o_pm, o_sm, o_err, o_byte};
            out_kind_reg <= o_kind;
            out_last_reg <= cmd.last;
        end
    end

    always_comb
    begin
        o_byte = 8'd0;
        o_kind = lp2sc_pkg::KIND_BYTE;
        o_err  = lp2sc_pkg::ERR_NONE;
        o_sm   = 1'b0;
        o_pm   = 1'b0;
        case (cmd.sel)
            lp2sc_pkg::SRC_STORE:
                o_byte = rd_data_reg;
            lp2sc_pkg::SRC_SC:
                o_byte = stat.sc_last ? 8'd1 : 8'd0;
            lp2sc_pkg::SRC_PAY:
            begin
                o_byte = pl_byte_reg;
                o_err  = pl_merge_reg ? pl_err_reg : lp2sc_pkg::ERR_NONE;
            end
            lp2sc_pkg::SRC_TAIL:
            begin
                o_kind = pl_kind_reg;
                o_err  = pl_err_reg;
                o_sm   = pl_sm_reg;
                o_pm   = pl_pm_reg;
            end
            default:
                o_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        stat.can_load  = !out_valid_reg || m_tready;
        stat.pl_cfgw   = pl_cfgw_reg;
        stat.pl_dump   = pl_dump_reg;
        stat.pl_sc     = pl_sc_reg;
        stat.pl_pay    = pl_pay_reg;
        stat.pl_tail   = pl_tail_reg;
        stat.scw_last  = (cnt_reg == ADDR_W'(3));
        stat.dump_last = (LEN_W'(cnt_reg) == plen_reg - LEN_W'(1));
        stat.sc_last   = (cnt_reg == (pl_sc4_reg ? ADDR_W'(3) : ADDR_W'(2)));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/h264_length_prefix_to_start_code_unit.sv =====
// Each request passes through ST_DISP and then emits its results in order:
// store dump, start code, payload byte, status or error item. An IDR first
// byte dumps the stored bytes, each through a registered store read (ST_DRD,
// ST_DEM). A configuration length that opens a unit first writes the start
// code into the store. One request in flight at a time. Reset (async, rst_n
// low) clears all parser state at once.
module h264_length_prefix_to_start_code_unit #(
    parameter int PARAM_STORE_BYTES = lp2sc_pkg::PARAM_STORE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // opcode
    input  logic        s_tlast,   // end_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], error_code[10:8],
                                   // sps_missing[11], pps_missing[12], zero
    output logic [1:0]  m_tuser,   // item_kind
    output logic        m_tlast    // end_of_run
);

    lp2sc_pkg::cmd_t  cmd;
    lp2sc_pkg::stat_t stat;

    lp2sc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lp2sc_dp #(
        .PARAM_STORE_BYTES (PARAM_STORE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_opcode (s_tuser),
        .in_byte   (s_tdata),
        .in_eob    (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .stat      (stat)
    );

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == lp2sc_pkg::KIND_STATUS |-> m_tlast)
        else $error("status item not last of its run");

    a_byte_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == lp2sc_pkg::KIND_BYTE |-> m_tdata[12:11] == 2'b00)
        else $error("missing flags set on a stream byte");

endmodule
